// ===== rtl/nps_pkg.sv =====
// Shared types and constants for the nearest point search block.
// Used by nps_ctrl, nps_datapath and nearest_point_search; no dependencies.
package nps_pkg;

  localparam int unsigned COORD_BITS     = 24;
  localparam int unsigned ID_BITS        = 31;
  localparam int unsigned DIST_BITS      = 2 * COORD_BITS + 2;
  localparam int unsigned SQ_BITS        = 2 * COORD_BITS + 1;
  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned CFG_DATA_BITS  = 2;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_DIMENSIONS = 1'b0;
  localparam logic REG_UNMAPPED   = 1'b1;

  localparam logic [1:0] DIM_FLAT = 2'd2;
  localparam logic [1:0] DIM_RESET = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                kind;
    logic                restart;
    coord_t              coord_x;
    coord_t              coord_y;
    coord_t              coord_z;
    logic [ID_BITS-1:0]  point_id;
  } req_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  dest_id;
    logic [ID_BITS-1:0]  nearest_id;
    logic                found;
    logic                unmapped_error;
    logic                store_overflowed;
  } res_t;

  typedef struct packed {
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic [ID_BITS-1:0]  id;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // store the accepted point
    logic query;    // latch the query point, clear the running best
    logic issue;    // read the entry at the scan index, advance it
    logic publish;  // register the result and strobe it
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;       // store holds no point
    logic last_issue;  // scan index is at the last stored entry
    logic pipe_empty;  // no entry in flight in the distance pipeline
  } sts_t;

endpackage

// ===== rtl/nps_ctrl.sv =====
// Sequencer for nearest point search: accepts requests, steps the scan, publishes.
// Depends on nps_pkg (cmd_t, sts_t, req_t kinds).
module nps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          kind_i,
  input  nps_pkg::sts_t sts_i,
  output nps_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i == nps_pkg::KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.query = 1'b1;
            state_d     = sts_i.empty ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/nps_datapath.sv =====
// Point store, scan counter, distance pipeline and running best for nearest point search.
// Depends on nps_pkg; driven by nps_ctrl through cmd_t / sts_t.
module nps_datapath #(
  parameter int unsigned MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nps_pkg::req_t                      req_i,
  input  nps_pkg::cmd_t                      cmd_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [nps_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output nps_pkg::sts_t                      sts_o,
  output logic                               res_valid_o,
  output nps_pkg::res_t                      res_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW = nps_pkg::COORD_BITS;
  localparam int unsigned IW = nps_pkg::ID_BITS;
  localparam int unsigned SW = nps_pkg::SQ_BITS;
  localparam int unsigned DW = nps_pkg::DIST_BITS;

  // configuration
  logic [1:0] dims_q;
  logic       unm_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q    <= nps_pkg::DIM_RESET;
      unm_err_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nps_pkg::REG_DIMENSIONS: dims_q    <= cfg_data_i[1:0];
        nps_pkg::REG_UNMAPPED:   unm_err_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic flat;
  assign flat = (dims_q == nps_pkg::DIM_FLAT);

  // store fill and overflow
  logic [NW-1:0] count_q, count_d, base_cnt;
  logic          ovf_q, ovf_d;
  logic          do_write;

  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    do_write = 1'b0;
    base_cnt = req_i.restart ? '0 : count_q;
    if (cmd_i.load) begin
      if (req_i.restart) ovf_d = 1'b0;
      if (base_cnt < NW'(MAX_POINTS)) begin
        do_write = 1'b1;
        count_d  = base_cnt + NW'(1);
      end else begin
        count_d = base_cnt;
        ovf_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // point memory, registered read
  nps_pkg::entry_t mem [MAX_POINTS];
  nps_pkg::entry_t rd_q;
  nps_pkg::entry_t wr_entry;
  logic [NW-1:0]   scan_idx_q;

  assign wr_entry.x  = req_i.coord_x;
  assign wr_entry.y  = req_i.coord_y;
  assign wr_entry.z  = req_i.coord_z;
  assign wr_entry.id = req_i.point_id;

  always_ff @(posedge clk_i) begin
    if (do_write) mem[base_cnt[AW-1:0]] <= wr_entry;
    if (cmd_i.issue) rd_q <= mem[scan_idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
    end else if (cmd_i.query) begin
      scan_idx_q <= '0;
    end else if (cmd_i.issue) begin
      scan_idx_q <= scan_idx_q + NW'(1);
    end
  end

  // query point
  nps_pkg::coord_t qx_q, qy_q, qz_q;
  logic [IW-1:0]   qid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      qx_q  <= req_i.coord_x;
      qy_q  <= req_i.coord_y;
      qz_q  <= req_i.coord_z;
      qid_q <= req_i.point_id;
    end
  end

  // pipeline valid bits: read data, differences, squares, sum
  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 2: coordinate differences
  logic signed [CW:0] dx_q, dy_q, dz_q;
  logic [IW-1:0]      id2_q;

  always_ff @(posedge clk_i) begin
    dx_q  <= (CW+1)'(qx_q) - (CW+1)'(rd_q.x);
    dy_q  <= (CW+1)'(qy_q) - (CW+1)'(rd_q.y);
    dz_q  <= flat ? '0 : (CW+1)'(qz_q) - (CW+1)'(rd_q.z);
    id2_q <= rd_q.id;
  end

  // stage 3: squares (always non-negative, fit in SW bits)
  logic signed [2*CW+1:0] sqx, sqy, sqz;
  logic [SW-1:0]          sqx_q, sqy_q, sqz_q;
  logic [IW-1:0]          id3_q;

  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;
  assign sqz = dz_q * dz_q;

  always_ff @(posedge clk_i) begin
    sqx_q <= sqx[SW-1:0];
    sqy_q <= sqy[SW-1:0];
    sqz_q <= sqz[SW-1:0];
    id3_q <= id2_q;
  end

  // stage 4: squared distance
  logic [DW-1:0] dist_q;
  logic [IW-1:0] id4_q;

  always_ff @(posedge clk_i) begin
    dist_q <= DW'(sqx_q) + DW'(sqy_q) + DW'(sqz_q);
    id4_q  <= id3_q;
  end

  // running best; equal distance goes to the smaller id
  logic          found_q;
  logic [DW-1:0] best_dist_q;
  logic [IW-1:0] best_id_q;
  logic          better;

  always_comb begin
    priority if (!found_q)               better = 1'b1;
    else if (dist_q != best_dist_q)      better = (dist_q < best_dist_q);
    else                                 better = (id4_q < best_id_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.query) begin
      found_q <= 1'b0;
    end else if (v4_q) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && better) begin
      best_dist_q <= dist_q;
      best_id_q   <= id4_q;
    end
  end

  // result register
  logic          res_valid_q;
  nps_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.publish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      res_q.dest_id          <= qid_q;
      res_q.nearest_id       <= found_q ? best_id_q : '0;
      res_q.found            <= found_q;
      res_q.unmapped_error   <= !found_q && unm_err_q;
      res_q.store_overflowed <= ovf_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.last_issue = (scan_idx_q == count_q - NW'(1));
  assign sts_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q);

endmodule

// ===== rtl/nearest_point_search.sv =====
// Top level of the nearest point search block: sequencer plus datapath.
// Depends on nps_pkg, nps_ctrl and nps_datapath.
//
// Requests enter on req_i when start_i is high and busy_o is low. A load
// (kind = load) writes one source point into the store in the accepting cycle
// and leaves busy_o low, so loads can stream one per cycle; restart empties
// the store and clears the overflow flag first, and a load into a full store
// is dropped and sets the sticky overflow flag. A query scans every stored
// point through the single read port of the point memory, one entry per
// cycle, into a four-stage distance pipeline (read, difference, square, sum)
// and a best-so-far compare. After the last entry the sequencer waits for the
// pipeline to drain, then registers the result and strobes res_valid_o (an
// empty store skips the scan); busy_o stays high until the cycle before the
// strobe, so the next request may be accepted while the result is shown.
// res_valid_o is high for exactly one cycle and cannot be held off.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and are meant for idle time. Reset empties the store, clears the overflow
// flag, sets dimensions to 3 and unmapped error mode on; no clearing pass.
module nearest_point_search #(
  parameter int unsigned MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  nps_pkg::req_t                      req_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [nps_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic                               res_valid_o,
  output nps_pkg::res_t                      res_o
);

  nps_pkg::cmd_t cmd;
  nps_pkg::sts_t sts;

  nps_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (req_i.kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  nps_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
